// ----- rtl/rtadj_pkg.sv -----
// Shared command codes, status codes and controller/datapath interface types.
`default_nettype none

package rtadj_pkg;

   localparam logic [1:0] CMD_ROUTE    = 2'd0;
   localparam logic [1:0] CMD_TICK     = 2'd1;
   localparam logic [1:0] CMD_READ     = 2'd2;
   localparam logic [1:0] CMD_REGISTER = 2'd3;

   localparam logic [2:0] ST_NEW       = 3'd0;
   localparam logic [2:0] ST_EXISTED   = 3'd1;
   localparam logic [2:0] ST_NO_PARENT = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_DONE      = 3'd4;

   // Step commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       scan;
      logic       decide;
      logic       rd_t;
      logic       fresh_inc;
      logic       adj_set_t;
      logic       rd_p;
      logic       adj_set_p;
      logic       age_f;
      logic       age_a;
      logic       rd_slot;
      logic       resp;
      logic [2:0] status;
   } ctl_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic par_found;
      logic tgt_found;
      logic free_found;
      logic link_bit;
      logic cnt_end;
   } sts_type;

endpackage

`default_nettype wire

// ----- rtl/rtadj_dp.sv -----
// Datapath: address, freshness and adjacency memories, slot sweeps and result registers.
`default_nettype none

module rtadj_dp import rtadj_pkg::*; #(
   parameter int MAX_NODES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   output sts_type     sts,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_target_address,
   input  logic [31:0] req_parent_address,
   input  logic [3:0]  req_slot_index,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_target_slot,
   output logic [3:0]  rsp_parent_slot,
   output logic        rsp_paths_changed,
   output logic [15:0] rsp_adjacency_row,
   output logic [31:0] rsp_slot_address
);

   localparam int IDXW = $clog2(MAX_NODES);
   localparam int CNTW = $clog2(MAX_NODES + 1);

   // Memories; the valid vectors make never-written entries read as zero.
   logic [31:0]          addr_mem  [MAX_NODES];
   logic [7:0]           fresh_mem [MAX_NODES];
   logic [MAX_NODES-1:0] adj_mem   [MAX_NODES];

   logic [31:0]          addr_rd_ff;
   logic [7:0]           fresh_rd_ff;
   logic [MAX_NODES-1:0] adj_rd_ff;

   logic [MAX_NODES-1:0] addr_vld_ff, addr_vld_in;
   logic [MAX_NODES-1:0] fresh_vld_ff, fresh_vld_in;
   logic [MAX_NODES-1:0] adj_vld_ff, adj_vld_in;
   logic                 addr_rdv_ff, addr_rdv_in;
   logic                 fresh_rdv_ff, fresh_rdv_in;
   logic                 adj_rdv_ff, adj_rdv_in;

   logic                 addr_we, addr_re;
   logic [IDXW-1:0]      addr_wa, addr_ra;
   logic [31:0]          addr_wd;
   logic                 fresh_we, fresh_re;
   logic [IDXW-1:0]      fresh_wa, fresh_ra;
   logic [7:0]           fresh_wd;
   logic                 adj_we, adj_re;
   logic [IDXW-1:0]      adj_wa, adj_ra;
   logic [MAX_NODES-1:0] adj_wd;

   logic [31:0]          addr_eff;
   logic [7:0]           fresh_eff;
   logic [MAX_NODES-1:0] adj_eff;

   // Request and search registers.
   logic [1:0]           cmd_ff, cmd_in;
   logic [31:0]          tgt_ff, tgt_in;
   logic [31:0]          par_ff, par_in;
   logic [IDXW-1:0]      sidx_ff, sidx_in;
   logic                 in_range_ff, in_range_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic                 par_found_ff, par_found_in;
   logic                 tgt_found_ff, tgt_found_in;
   logic                 free_found_ff, free_found_in;
   logic [IDXW-1:0]      p_ff, p_in;
   logic [IDXW-1:0]      tm_ff, tm_in;
   logic [IDXW-1:0]      free_ff, free_in;
   logic [IDXW-1:0]      t_ff, t_in;
   logic [MAX_NODES-1:0] stale_ff, stale_in;

   // Result registers.
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [3:0]           rsp_tslot_ff, rsp_tslot_in;
   logic [3:0]           rsp_pslot_ff, rsp_pslot_in;
   logic                 rsp_changed_ff, rsp_changed_in;
   logic [15:0]          rsp_row_ff, rsp_row_in;
   logic [31:0]          rsp_addr_ff, rsp_addr_in;

   logic                 cnt_end;
   logic                 proc;
   logic [CNTW-1:0]      pcnt;
   logic [IDXW-1:0]      pidx;
   logic [IDXW-1:0]      cnt_idx;
   logic [IDXW+3:0]      sidx_ext;
   logic [IDXW+3:0]      t_ext;
   logic [IDXW+3:0]      p_ext;
   logic [MAX_NODES+15:0] row_ext;
   logic [MAX_NODES-1:0] bit_p;
   logic [MAX_NODES-1:0] bit_t;
   logic                 is_route;
   logic                 link_ok;

   assign addr_eff  = addr_rdv_ff ? addr_rd_ff : '0;
   assign fresh_eff = fresh_rdv_ff ? fresh_rd_ff : '0;
   assign adj_eff   = adj_rdv_ff ? adj_rd_ff : '0;

   assign cnt_end  = (cnt_ff == CNTW'(MAX_NODES));
   assign proc     = (cnt_ff != '0);
   assign pcnt     = cnt_ff - CNTW'(1);
   assign pidx     = pcnt[IDXW-1:0];
   assign cnt_idx  = cnt_ff[IDXW-1:0];
   assign sidx_ext = {{IDXW{1'b0}}, req_slot_index};
   assign t_ext    = {4'b0000, t_ff};
   assign p_ext    = {4'b0000, p_ff};
   assign row_ext  = {16'h0000, adj_eff};
   assign bit_p    = MAX_NODES'(1) << p_ff;
   assign bit_t    = MAX_NODES'(1) << t_ff;
   assign is_route = (cmd_ff == CMD_ROUTE);
   assign link_ok  = (ctl.status == ST_NEW) || (ctl.status == ST_EXISTED);

   always_comb begin
      cmd_in        = cmd_ff;
      tgt_in        = tgt_ff;
      par_in        = par_ff;
      sidx_in       = sidx_ff;
      in_range_in   = in_range_ff;
      cnt_in        = cnt_ff;
      par_found_in  = par_found_ff;
      tgt_found_in  = tgt_found_ff;
      free_found_in = free_found_ff;
      p_in          = p_ff;
      tm_in         = tm_ff;
      free_in       = free_ff;
      t_in          = t_ff;
      stale_in      = stale_ff;

      addr_we  = 1'b0;
      addr_wa  = '0;
      addr_wd  = '0;
      addr_re  = 1'b0;
      addr_ra  = '0;
      fresh_we = 1'b0;
      fresh_wa = '0;
      fresh_wd = '0;
      fresh_re = 1'b0;
      fresh_ra = '0;
      adj_we   = 1'b0;
      adj_wa   = '0;
      adj_wd   = '0;
      adj_re   = 1'b0;
      adj_ra   = '0;

      if (ctl.load) begin
         cmd_in        = req_command;
         tgt_in        = req_target_address;
         par_in        = req_parent_address;
         sidx_in       = sidx_ext[IDXW-1:0];
         in_range_in   = (sidx_ext < (IDXW+4)'(MAX_NODES));
         cnt_in        = '0;
         par_found_in  = 1'b0;
         tgt_found_in  = 1'b0;
         free_found_in = 1'b0;
         stale_in      = '0;
      end

      // Sweeps read slot cnt and handle the slot read in the previous cycle.
      if (ctl.scan || ctl.age_f || ctl.age_a) begin
         cnt_in = cnt_end ? '0 : cnt_ff + CNTW'(1);
      end

      if (ctl.scan) begin
         addr_re = !cnt_end;
         addr_ra = cnt_idx;
         if (proc) begin
            if (addr_eff == par_ff && !par_found_ff) begin
               par_found_in = 1'b1;
               p_in         = pidx;
            end
            if (addr_eff == tgt_ff && !tgt_found_ff) begin
               tgt_found_in = 1'b1;
               tm_in        = pidx;
            end
            if (addr_eff == 32'd0 && !free_found_ff) begin
               free_found_in = 1'b1;
               free_in       = pidx;
            end
         end
      end

      if (ctl.decide) begin
         t_in = (is_route && tgt_found_ff) ? tm_ff : free_ff;
         if (free_found_ff && ((cmd_ff == CMD_REGISTER) ||
                               (is_route && par_found_ff && !tgt_found_ff))) begin
            addr_we = 1'b1;
            addr_wa = free_ff;
            addr_wd = tgt_ff;
         end
      end

      if (ctl.rd_t) begin
         fresh_re = 1'b1;
         fresh_ra = t_ff;
         adj_re   = 1'b1;
         adj_ra   = t_ff;
      end

      if (ctl.fresh_inc) begin
         fresh_we = 1'b1;
         fresh_wa = t_ff;
         fresh_wd = fresh_eff + 8'd1;
      end

      if (ctl.adj_set_t) begin
         adj_we = 1'b1;
         adj_wa = t_ff;
         adj_wd = adj_eff | bit_p;
      end

      if (ctl.rd_p) begin
         adj_re = 1'b1;
         adj_ra = p_ff;
      end

      if (ctl.adj_set_p) begin
         adj_we = 1'b1;
         adj_wa = p_ff;
         adj_wd = adj_eff | bit_t;
      end

      // Slot 0 never ages.
      if (ctl.age_f) begin
         fresh_re = !cnt_end;
         fresh_ra = cnt_idx;
         if (proc && pidx != '0) begin
            if (fresh_eff != 8'd0) begin
               fresh_we = 1'b1;
               fresh_wa = pidx;
               fresh_wd = 8'd0;
            end else begin
               stale_in[pidx] = 1'b1;
            end
         end
      end

      // A stale slot loses its whole row, and every row loses the stale columns.
      if (ctl.age_a) begin
         adj_re = !cnt_end;
         adj_ra = cnt_idx;
         if (proc) begin
            adj_we = 1'b1;
            adj_wa = pidx;
            adj_wd = stale_ff[pidx] ? '0 : (adj_eff & ~stale_ff);
         end
      end

      if (ctl.rd_slot) begin
         addr_re = 1'b1;
         addr_ra = sidx_ff;
         adj_re  = 1'b1;
         adj_ra  = sidx_ff;
      end

      addr_vld_in  = addr_vld_ff;
      fresh_vld_in = fresh_vld_ff;
      adj_vld_in   = adj_vld_ff;
      if (addr_we) begin
         addr_vld_in[addr_wa] = 1'b1;
      end
      if (fresh_we) begin
         fresh_vld_in[fresh_wa] = 1'b1;
      end
      if (adj_we) begin
         adj_vld_in[adj_wa] = 1'b1;
      end
      addr_rdv_in  = addr_re ? addr_vld_ff[addr_ra] : addr_rdv_ff;
      fresh_rdv_in = fresh_re ? fresh_vld_ff[fresh_ra] : fresh_rdv_ff;
      adj_rdv_in   = adj_re ? adj_vld_ff[adj_ra] : adj_rdv_ff;
   end

   always_comb begin
      rsp_strobe_in  = ctl.resp;
      rsp_status_in  = rsp_status_ff;
      rsp_tslot_in   = rsp_tslot_ff;
      rsp_pslot_in   = rsp_pslot_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_addr_in    = rsp_addr_ff;
      if (ctl.resp) begin
         rsp_status_in = ctl.status;
         rsp_tslot_in  = ((is_route && link_ok) ||
                          (cmd_ff == CMD_REGISTER && ctl.status == ST_DONE)) ?
                         t_ext[3:0] : 4'd0;
         rsp_pslot_in  = (is_route && ctl.status != ST_NO_PARENT) ? p_ext[3:0] : 4'd0;
         rsp_changed_in = (is_route && ctl.status == ST_NEW) ||
                          (cmd_ff == CMD_TICK && (|stale_ff));
         rsp_row_in    = (cmd_ff == CMD_READ && in_range_ff) ? row_ext[15:0] : 16'd0;
         rsp_addr_in   = (cmd_ff == CMD_READ && in_range_ff) ? addr_eff : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (addr_we) begin
         addr_mem[addr_wa] <= addr_wd;
      end
      if (addr_re) begin
         addr_rd_ff <= addr_mem[addr_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (fresh_we) begin
         fresh_mem[fresh_wa] <= fresh_wd;
      end
      if (fresh_re) begin
         fresh_rd_ff <= fresh_mem[fresh_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_wa] <= adj_wd;
      end
      if (adj_re) begin
         adj_rd_ff <= adj_mem[adj_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_vld_ff   <= '0;
         fresh_vld_ff  <= '0;
         adj_vld_ff    <= '0;
         addr_rdv_ff   <= 1'b0;
         fresh_rdv_ff  <= 1'b0;
         adj_rdv_ff    <= 1'b0;
         cmd_ff        <= CMD_ROUTE;
         cnt_ff        <= '0;
         par_found_ff  <= 1'b0;
         tgt_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         stale_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         addr_vld_ff   <= addr_vld_in;
         fresh_vld_ff  <= fresh_vld_in;
         adj_vld_ff    <= adj_vld_in;
         addr_rdv_ff   <= addr_rdv_in;
         fresh_rdv_ff  <= fresh_rdv_in;
         adj_rdv_ff    <= adj_rdv_in;
         cmd_ff        <= cmd_in;
         cnt_ff        <= cnt_in;
         par_found_ff  <= par_found_in;
         tgt_found_ff  <= tgt_found_in;
         free_found_ff <= free_found_in;
         stale_ff      <= stale_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff         <= tgt_in;
      par_ff         <= par_in;
      sidx_ff        <= sidx_in;
      in_range_ff    <= in_range_in;
      p_ff           <= p_in;
      tm_ff          <= tm_in;
      free_ff        <= free_in;
      t_ff           <= t_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_tslot_ff   <= rsp_tslot_in;
      rsp_pslot_ff   <= rsp_pslot_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_addr_ff    <= rsp_addr_in;
   end

   assign sts.par_found  = par_found_ff;
   assign sts.tgt_found  = tgt_found_ff;
   assign sts.free_found = free_found_ff;
   assign sts.link_bit   = adj_eff[p_ff];
   assign sts.cnt_end    = cnt_end;

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_target_slot   = rsp_tslot_ff;
   assign rsp_parent_slot   = rsp_pslot_ff;
   assign rsp_paths_changed = rsp_changed_ff;
   assign rsp_adjacency_row = rsp_row_ff;
   assign rsp_slot_address  = rsp_addr_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held for two cycles");

   a_slot0_never_stale: assert property (@(posedge clock) disable iff (reset)
      !stale_ff[0])
      else $error("slot 0 marked stale");

   a_link_needs_slots: assert property (@(posedge clock) disable iff (reset)
      ctl.rd_t |-> (par_found_ff && (tgt_found_ff || free_found_ff)))
      else $error("link check without parent and target slots");

endmodule

`default_nettype wire

// ----- rtl/rtadj_ctrl.sv -----
// Controller: sequences the sweeps and memory steps of each command.
`default_nettype none

module rtadj_ctrl import rtadj_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_command,
   input  sts_type    sts,
   output ctl_type    ctl,
   output logic       busy
);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_SCAN   = 11'b000_0000_0010,
      S_DECIDE = 11'b000_0000_0100,
      S_RD_T   = 11'b000_0000_1000,
      S_CHK    = 11'b000_0001_0000,
      S_RD_P   = 11'b000_0010_0000,
      S_WR_P   = 11'b000_0100_0000,
      S_AGE_F  = 11'b000_1000_0000,
      S_AGE_A  = 11'b001_0000_0000,
      S_READ   = 11'b010_0000_0000,
      S_RESP   = 11'b100_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [2:0] status_ff, status_in;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      status_in = status_ff;
      ctl       = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               cmd_in   = req_command;
               case (req_command)
                  CMD_ROUTE:    state_in = S_SCAN;
                  CMD_REGISTER: state_in = S_SCAN;
                  CMD_TICK:     state_in = S_AGE_F;
                  default:      state_in = S_READ;
               endcase
            end
         end
         S_SCAN: begin
            ctl.scan = 1'b1;
            if (sts.cnt_end) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            ctl.decide = 1'b1;
            if (cmd_ff == CMD_REGISTER) begin
               status_in = sts.free_found ? ST_DONE : ST_FULL;
               state_in  = S_RESP;
            end else if (!sts.par_found) begin
               status_in = ST_NO_PARENT;
               state_in  = S_RESP;
            end else if (!sts.tgt_found && !sts.free_found) begin
               status_in = ST_FULL;
               state_in  = S_RESP;
            end else begin
               state_in = S_RD_T;
            end
         end
         S_RD_T: begin
            ctl.rd_t = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            ctl.fresh_inc = 1'b1;
            if (sts.link_bit) begin
               status_in = ST_EXISTED;
               state_in  = S_RESP;
            end else begin
               ctl.adj_set_t = 1'b1;
               state_in      = S_RD_P;
            end
         end
         S_RD_P: begin
            ctl.rd_p = 1'b1;
            state_in = S_WR_P;
         end
         S_WR_P: begin
            ctl.adj_set_p = 1'b1;
            status_in     = ST_NEW;
            state_in      = S_RESP;
         end
         S_AGE_F: begin
            ctl.age_f = 1'b1;
            if (sts.cnt_end) begin
               state_in = S_AGE_A;
            end
         end
         S_AGE_A: begin
            ctl.age_a = 1'b1;
            if (sts.cnt_end) begin
               status_in = ST_DONE;
               state_in  = S_RESP;
            end
         end
         S_READ: begin
            ctl.rd_slot = 1'b1;
            status_in   = ST_DONE;
            state_in    = S_RESP;
         end
         S_RESP: begin
            ctl.resp   = 1'b1;
            ctl.status = status_ff;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cmd_ff    <= CMD_ROUTE;
         status_ff <= ST_DONE;
      end else begin
         state_ff  <= state_in;
         cmd_ff    <= cmd_in;
         status_ff <= status_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not start work");

   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(ctl.resp))
      else $error("returned to idle without issuing a result");

endmodule

`default_nettype wire

// ----- rtl/route_adjacency_table_with_aging_top.sv -----
// Top level of the route adjacency table with aging.
`default_nettype none

// One command is taken per transfer while busy is low; its single result comes
// back on the rsp_ ports for exactly one cycle, marked by rsp_strobe, and the
// receiver cannot stall it. The block works on one command at a time because
// every step reads one slot per cycle through memories with one read port and
// one write port. A route report that adds a link runs one address sweep plus
// the freshness and adjacency read-modify-writes; when the link already existed
// it stops after the freshness update, and it ends early after the sweep when
// the parent is unknown or the table is full. A register runs one address
// sweep; a lifetime tick runs a freshness sweep, then an adjacency row sweep;
// a read slot does a single read. busy drops in the strobe cycle, so the next
// command can be taken at the edge that ends it. After reset the tables read
// as empty at once, with no clearing pass.
module route_adjacency_table_with_aging_top import rtadj_pkg::*; #(
   parameter int MAX_NODES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_target_address,
   input  logic [31:0] req_parent_address,
   input  logic [3:0]  req_slot_index,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_target_slot,
   output logic [3:0]  rsp_parent_slot,
   output logic        rsp_paths_changed,
   output logic [15:0] rsp_adjacency_row,
   output logic [31:0] rsp_slot_address
);

   ctl_type ctl;
   sts_type sts;

   rtadj_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .sts         (sts),
      .ctl         (ctl),
      .busy        (busy)
   );

   rtadj_dp #(
      .MAX_NODES (MAX_NODES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req_command        (req_command),
      .req_target_address (req_target_address),
      .req_parent_address (req_parent_address),
      .req_slot_index     (req_slot_index),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_target_slot    (rsp_target_slot),
      .rsp_parent_slot    (rsp_parent_slot),
      .rsp_paths_changed  (rsp_paths_changed),
      .rsp_adjacency_row  (rsp_adjacency_row),
      .rsp_slot_address   (rsp_slot_address)
   );

endmodule

`default_nettype wire
